// ===== design/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon test block.
`default_nettype none

package pip_pkg;

  localparam int MAX_VERTICES = 128;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int LAT_W        = 31;
  localparam int LON_W        = 32;
  localparam int VCOUNT_W     = 8;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_LAST,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } vertex_t;

endpackage

`default_nettype wire

// ===== design/point_in_polygon_test.sv =====
// Point-in-polygon test by crossing number over a stored vertex list.
//
// Input words (command, latitude, longitude) arrive on item_valid/item_stall;
// one result word (inside_res, status, vertex_count) leaves on
// result_valid/result_stall for every input word, in order.
// A clear word empties the polygon and an append word stores one vertex;
// each passes through the finish state into the result register, and the
// next word is taken only once it is loaded. An append to a full store
// leaves the store unchanged and reports status 1.
// A test word reads the vertex store through its single read port, first
// the last vertex to form the closing edge and then every vertex in order,
// and feeds a two-stage multiply-compare edge unit; the next word is taken
// only after the edge unit drains and the result is loaded. A test with
// fewer than two vertices is handled like a clear word and gives 0.
// One word is worked on at a time; item_stall is high from acceptance until
// its result is loaded into the output register. A result waiting under
// result_stall does not block acceptance of the next word, but that word's
// result waits until the register is free.
// Synchronous reset empties the polygon and discards any pending result;
// the vertex store itself is not cleared.
`default_nettype none

module point_in_polygon_test (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              item_valid,
  output logic                             item_stall,
  input  wire [1:0]                        command,
  input  wire signed [pip_pkg::LAT_W-1:0]  latitude,
  input  wire signed [pip_pkg::LON_W-1:0]  longitude,
  output logic                             result_valid,
  input  wire                              result_stall,
  output logic                             inside_res,
  output logic                             status,
  output logic [pip_pkg::VCOUNT_W-1:0]     vertex_count
);

  pip_pkg::state_t               state;
  pip_pkg::state_t               state_next;
  logic [pip_pkg::CNT_W-1:0]     count_held;
  logic [pip_pkg::ADDR_W-1:0]    rd_idx;
  logic [pip_pkg::ADDR_W-1:0]    last_addr;
  logic                          data_valid;
  logic                          data_prev_only;
  pip_pkg::vertex_t              point;
  pip_pkg::vertex_t              prev_vtx;
  pip_pkg::vertex_t              rd_data;
  pip_pkg::vertex_t              wr_data;
  logic                          parity;
  logic                          pend_inside;
  logic                          pend_status;
  logic                          accept;
  logic                          store_full;
  logic                          wr_en;
  logic                          rd_en;
  logic [pip_pkg::ADDR_W-1:0]    rd_addr;
  logic                          out_free;
  logic                          edge_valid;
  logic                          flip_valid;
  logic                          flip;
  logic                          edge_busy;

  assign item_stall = (state != pip_pkg::ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign store_full = (count_held >= pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES));
  assign last_addr  = pip_pkg::ADDR_W'(count_held - pip_pkg::CNT_W'(1));
  assign out_free   = !result_valid || !result_stall;
  assign wr_en      = accept && (command == pip_pkg::CMD_APPEND) && !store_full;
  assign wr_data    = '{lat: latitude, lon: longitude};
  assign edge_valid = data_valid && !data_prev_only;

  pip_vertex_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pip_pkg::ADDR_W'(count_held)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pip_edge_unit u_edge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (edge_valid),
    .cur        (rd_data),
    .prev       (prev_vtx),
    .point      (point),
    .flip_valid (flip_valid),
    .flip       (flip),
    .busy       (edge_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pip_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = rd_idx;
    unique case (state)
      pip_pkg::ST_IDLE: begin
        if (item_valid) begin
          if ((command == pip_pkg::CMD_TEST) &&
              (count_held >= pip_pkg::CNT_W'(2))) begin
            state_next = pip_pkg::ST_READ_LAST;
          end else begin
            state_next = pip_pkg::ST_FINISH;
          end
        end
      end
      pip_pkg::ST_READ_LAST: begin
        rd_en      = 1'b1;
        rd_addr    = last_addr;
        state_next = pip_pkg::ST_WALK;
      end
      pip_pkg::ST_WALK: begin
        rd_en = 1'b1;
        if (rd_idx == last_addr) begin
          state_next = pip_pkg::ST_DRAIN;
        end
      end
      pip_pkg::ST_DRAIN: begin
        if (!data_valid && !edge_busy) begin
          state_next = pip_pkg::ST_FINISH;
        end
      end
      pip_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = pip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pip_pkg::ST_IDLE;
      end
    endcase
  end

  // Command decode and vertex count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_held <= '0;
    end else if (accept) begin
      unique case (command)
        pip_pkg::CMD_CLEAR: begin
          count_held <= '0;
        end
        pip_pkg::CMD_APPEND: begin
          if (!store_full) begin
            count_held <= count_held + pip_pkg::CNT_W'(1);
          end
        end
        default: begin
          count_held <= count_held;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      point       <= wr_data;
      pend_status <= (command == pip_pkg::CMD_APPEND) && store_full;
    end
    if (state == pip_pkg::ST_READ_LAST) begin
      rd_idx <= '0;
    end else if (state == pip_pkg::ST_WALK) begin
      rd_idx <= rd_idx + pip_pkg::ADDR_W'(1);
    end
    // Each vertex read becomes the previous vertex of the next edge.
    if (data_valid) begin
      prev_vtx <= rd_data;
    end
    data_prev_only <= (state == pip_pkg::ST_READ_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid  <= 1'b0;
      parity      <= 1'b0;
      pend_inside <= 1'b0;
    end else begin
      data_valid <= rd_en;
      if (accept) begin
        parity      <= 1'b0;
        pend_inside <= 1'b0;
      end else if (flip_valid && flip) begin
        parity <= ~parity;
      end
      if ((state == pip_pkg::ST_DRAIN) && (state_next == pip_pkg::ST_FINISH)) begin
        pend_inside <= parity;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == pip_pkg::ST_FINISH) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == pip_pkg::ST_FINISH) && out_free) begin
      inside_res   <= pend_inside;
      status       <= pend_status;
      vertex_count <= pip_pkg::VCOUNT_W'(count_held);
    end
  end

endmodule

`default_nettype wire

// ===== design/pip_vertex_mem.sv =====
// Vertex store: one write port, one read port with registered read data.
`default_nettype none

module pip_vertex_mem (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire [pip_pkg::ADDR_W-1:0]  wr_addr,
  input  pip_pkg::vertex_t           wr_data,
  input  wire                        rd_en,
  input  wire [pip_pkg::ADDR_W-1:0]  rd_addr,
  output pip_pkg::vertex_t           rd_data
);

  pip_pkg::vertex_t mem [pip_pkg::MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/pip_edge_unit.sv =====
// Two-stage crossing test for one polygon edge against the test point.
`default_nettype none

module pip_edge_unit (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  pip_pkg::vertex_t  cur,
  input  pip_pkg::vertex_t  prev,
  input  pip_pkg::vertex_t  point,
  output logic              flip_valid,
  output logic              flip,
  output logic              busy
);

  // First stage: straddle test and coordinate differences.
  logic               v1;
  logic               strad1;
  logic               dy_pos1;
  logic signed [31:0] a1;
  logic signed [32:0] b1;
  logic signed [32:0] c1;
  logic signed [31:0] d1;

  // Second stage: the two cross products.
  logic               v2;
  logic               strad2;
  logic               dy_pos2;
  logic signed [64:0] lhs2;
  logic signed [64:0] rhs2;

  logic               straddle;
  logic               west;

  always_comb begin
    straddle = ((cur.lat < point.lat) && (prev.lat >= point.lat)) ||
               ((prev.lat < point.lat) && (cur.lat >= point.lat));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      strad1  <= straddle;
      dy_pos1 <= prev.lat > cur.lat;
      a1      <= 32'(point.lat) - 32'(cur.lat);
      b1      <= 33'(prev.lon) - 33'(cur.lon);
      c1      <= 33'(point.lon) - 33'(cur.lon);
      d1      <= 32'(prev.lat) - 32'(cur.lat);
    end
    if (v1) begin
      strad2  <= strad1;
      dy_pos2 <= dy_pos1;
      lhs2    <= a1 * b1;
      rhs2    <= c1 * d1;
    end
  end

  // The sign of dy decides which way the cross-multiplied compare points.
  always_comb begin
    west       = dy_pos2 ? (lhs2 < rhs2) : (lhs2 > rhs2);
    flip       = strad2 && west;
    flip_valid = v2;
    busy       = v1 || v2;
  end

endmodule

`default_nettype wire

// ===== design/pip_checker.sv =====
// Port-level checks for the point-in-polygon test block, bound to the top level.
`default_nettype none

module pip_checker (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              item_valid,
  input  wire                              item_stall,
  input  wire [1:0]                        command,
  input  wire signed [pip_pkg::LAT_W-1:0]  latitude,
  input  wire signed [pip_pkg::LON_W-1:0]  longitude,
  input  wire                              result_valid,
  input  wire                              result_stall,
  input  wire                              inside_res,
  input  wire                              status,
  input  wire [pip_pkg::VCOUNT_W-1:0]      vertex_count
);

  // A stalled result word holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(inside_res) && $stable(status) && $stable(vertex_count))
    else $error("stalled result word changed");

  // Only one word is worked on at a time.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second word accepted while one is in progress");

  // A refused append never reports inside.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && status |-> !inside_res)
    else $error("status and inside_res both set");

  // A refused append happens only with a full store.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && status |->
      vertex_count == pip_pkg::VCOUNT_W'(pip_pkg::MAX_VERTICES))
    else $error("store-full status with a store that is not full");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (.*);

`default_nettype wire
